>>> design/mavx_pkg.sv
// Shared constants and types for the moving-average crossover block.
package mavx_pkg;

  // Price and mean widths follow the fixed field widths of the channels.
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned TOTAL_W = 32;

  // Default window lengths for the short and long means.
  localparam int unsigned SHORT_LEN_DEF = 20;
  localparam int unsigned LONG_LEN_DEF  = 50;

  // Trade signal codes, two-bit signed.
  localparam logic signed [1:0] SIG_NONE = 2'sb00;
  localparam logic signed [1:0] SIG_BUY  = 2'sb01;
  localparam logic signed [1:0] SIG_SELL = 2'sb11;

  // Load enables for the two pipeline stages behind the input stage.
  typedef struct packed {
    logic ld_mult;  // stage that holds the partial products
    logic ld_out;   // result register stage
  } stage_en_t;

endpackage

>>> design/mavx_const_div.sv
// Two-stage divider of an unsigned sum by a constant, by reciprocal multiply.
module mavx_const_div #(
  parameter int unsigned XW      = 38,
  parameter int unsigned DIVISOR = 20
) (
  input  logic                           clk_i,
  input  mavx_pkg::stage_en_t            en_i,
  input  logic [XW-1:0]                  x_i,
  output logic [mavx_pkg::PRICE_W-1:0]   q_o
);

  // floor(x / D) = (x * M) >> SHIFT for every x below 2^XW, M = ceil(2^SHIFT / D).
  localparam int unsigned SHIFT = XW + $clog2(DIVISOR);
  localparam int unsigned MW    = XW + 1;
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MAGIC = MAGIC_FULL[MW-1:0];

  // Operand split into halves so that each partial product stays narrow.
  localparam int unsigned XL = XW / 2;
  localparam int unsigned XH = XW - XL;
  localparam int unsigned ML = MW / 2;
  localparam int unsigned MH = MW - ML;
  localparam int unsigned PW = XW + MW;

  localparam logic [ML-1:0] MAGIC_LO = MAGIC[ML-1:0];
  localparam logic [MH-1:0] MAGIC_HI = MAGIC[MW-1:ML];

  logic [XL-1:0]    x_lo;
  logic [XH-1:0]    x_hi;
  logic [XL+ML-1:0] pp_ll_q;
  logic [XL+MH-1:0] pp_lh_q;
  logic [XH+ML-1:0] pp_hl_q;
  logic [XH+MH-1:0] pp_hh_q;
  logic [PW-1:0]    prod;

  assign x_lo = x_i[XL-1:0];
  assign x_hi = x_i[XW-1:XL];

  // First stage: four narrow partial products.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_mult) begin
      pp_ll_q <= (XL+ML)'(x_lo) * (XL+ML)'(MAGIC_LO);
      pp_lh_q <= (XL+MH)'(x_lo) * (XL+MH)'(MAGIC_HI);
      pp_hl_q <= (XH+ML)'(x_hi) * (XH+ML)'(MAGIC_LO);
      pp_hh_q <= (XH+MH)'(x_hi) * (XH+MH)'(MAGIC_HI);
    end
  end

  // Second stage: align and add the partial products, keep the quotient bits.
  assign prod = PW'(pp_ll_q)
              + (PW'(pp_lh_q) << ML)
              + (PW'(pp_hl_q) << XL)
              + (PW'(pp_hh_q) << (XL + ML));

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      q_o <= prod[SHIFT +: mavx_pkg::PRICE_W];
    end
  end

endmodule

>>> design/moving_average_crossover.sv
// Top level of the moving-average crossover detector.
//
// One closing price enters per request on the input channel (in_valid_i,
// in_stall_o, close_price_i). For every price the block returns one result
// request on the output channel: the short and long window means, their
// ready bits, the trade signal (1 buy, -1 sell, 0 none) and the saturating
// buy and sell totals.
// A new price can be taken in every cycle while in_stall_o is low. The
// window sums update as the price enters, the next stage forms the
// partial products of the reciprocal divides and the bullish compare, and
// the last stage adds the products and detects the crossover into the
// result register.
// When the receiver stalls, the result register holds its request and the
// stages behind it keep filling; the input stalls only once every stage
// holds a request.
// Reset clears the delay line, both sums, the item count, the bullish flag,
// both totals and all valid bits; the block takes a price right after reset.
module moving_average_crossover #(
  parameter int unsigned SHORT_LEN = mavx_pkg::SHORT_LEN_DEF,
  parameter int unsigned LONG_LEN  = mavx_pkg::LONG_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mavx_pkg::PRICE_W-1:0]        close_price_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mavx_pkg::PRICE_W-1:0]        short_average_o,
  output logic [mavx_pkg::PRICE_W-1:0]        long_average_o,
  output logic                                short_ready_o,
  output logic                                long_ready_o,
  output logic signed [1:0]                   trade_signal_o,
  output logic [mavx_pkg::TOTAL_W-1:0]        buy_total_o,
  output logic [mavx_pkg::TOTAL_W-1:0]        sell_total_o
);

  localparam int unsigned HIST_DEPTH =
    (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
  localparam int unsigned SEEN_MAX = HIST_DEPTH + 1;
  localparam int unsigned CNT_W    = $clog2(SEEN_MAX + 1);
  localparam int unsigned SSUM_W   = mavx_pkg::PRICE_W + $clog2(SHORT_LEN + 1);
  localparam int unsigned LSUM_W   = mavx_pkg::PRICE_W + $clog2(LONG_LEN + 1);
  localparam int unsigned MAX_SUM_W = (SSUM_W > LSUM_W) ? SSUM_W : LSUM_W;
  localparam int unsigned WIN_W    = $clog2(HIST_DEPTH + 1);
  localparam int unsigned CMP_W    = MAX_SUM_W + WIN_W;

  // Pipeline handshake.
  logic v1_q, v2_q, vo_q;
  logic room1, room2, adv_out, accept;
  mavx_pkg::stage_en_t stage_en;

  assign adv_out = !vo_q || !out_stall_i;
  assign room2   = !v2_q || adv_out;
  assign room1   = !v1_q || room2;
  assign accept  = in_valid_i && room1;

  assign in_stall_o       = !room1;
  assign out_valid_o      = vo_q;
  assign stage_en.ld_mult = room2;
  assign stage_en.ld_out  = adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (room1) begin
        v1_q <= accept;
      end
      if (room2) begin
        v2_q <= v1_q;
      end
      if (adv_out) begin
        vo_q <= v2_q;
      end
    end
  end

  // Delay line and running window sums, updated as each price enters.
  logic [mavx_pkg::PRICE_W-1:0] hist_q [HIST_DEPTH];
  logic [SSUM_W-1:0]            fast_sum_q, fast_sum_d;
  logic [LSUM_W-1:0]            slow_sum_q, slow_sum_d;
  logic [CNT_W-1:0]             seen_q, seen_d;
  logic                         short_rdy_d, long_rdy_d;

  assign fast_sum_d  = fast_sum_q + SSUM_W'(close_price_i)
                     - SSUM_W'(hist_q[SHORT_LEN-1]);
  assign slow_sum_d  = slow_sum_q + LSUM_W'(close_price_i)
                     - LSUM_W'(hist_q[LONG_LEN-1]);
  assign seen_d      = (seen_q < CNT_W'(SEEN_MAX)) ? seen_q + CNT_W'(1) : seen_q;
  assign short_rdy_d = seen_d >= CNT_W'(SHORT_LEN);
  assign long_rdy_d  = seen_d >= CNT_W'(LONG_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      fast_sum_q <= '0;
      slow_sum_q <= '0;
      seen_q     <= '0;
    end else if (accept) begin
      hist_q[0] <= close_price_i;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      fast_sum_q <= fast_sum_d;
      slow_sum_q <= slow_sum_d;
      seen_q     <= seen_d;
    end
  end

  // First stage: sums that count, ready bits and the signal enable.
  logic [SSUM_W-1:0] s1_short_q;
  logic [LSUM_W-1:0] s1_long_q;
  logic              s1_short_rdy_q, s1_long_rdy_q, s1_sig_en_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_short_q     <= short_rdy_d ? fast_sum_d : '0;
      s1_long_q      <= long_rdy_d ? slow_sum_d : '0;
      s1_short_rdy_q <= short_rdy_d;
      s1_long_rdy_q  <= long_rdy_d;
      s1_sig_en_q    <= seen_q >= CNT_W'(LONG_LEN);
    end
  end

  // Second stage: exact bullish compare of the cross-scaled sums.
  logic [CMP_W-1:0] short_scaled, long_scaled;
  logic             s2_bull_q, s2_short_rdy_q, s2_long_rdy_q, s2_sig_en_q;

  assign short_scaled = CMP_W'(s1_short_q) * CMP_W'(LONG_LEN);
  assign long_scaled  = CMP_W'(s1_long_q) * CMP_W'(SHORT_LEN);

  always_ff @(posedge clk_i) begin
    if (room2) begin
      s2_bull_q      <= short_scaled > long_scaled;
      s2_short_rdy_q <= s1_short_rdy_q;
      s2_long_rdy_q  <= s1_long_rdy_q;
      s2_sig_en_q    <= s1_sig_en_q;
    end
  end

  // Window means, divided over the last two stages.
  mavx_const_div #(
    .XW      (SSUM_W),
    .DIVISOR (SHORT_LEN)
  ) u_short_div (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .x_i   (s1_short_q),
    .q_o   (short_average_o)
  );

  mavx_const_div #(
    .XW      (LSUM_W),
    .DIVISOR (LONG_LEN)
  ) u_long_div (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .x_i   (s1_long_q),
    .q_o   (long_average_o)
  );

  // Crossover detection against the previous item's bullish flag.
  logic                          prev_bull_q;
  logic                          is_buy, is_sell;
  logic [mavx_pkg::TOTAL_W-1:0]  buy_q, buy_d, sell_q, sell_d;
  logic signed [1:0]             sig_d;
  logic                          out_load;

  assign out_load = adv_out && v2_q;
  assign is_buy   = s2_sig_en_q && !prev_bull_q && s2_bull_q;
  assign is_sell  = s2_sig_en_q && prev_bull_q && !s2_bull_q;

  always_comb begin
    sig_d  = mavx_pkg::SIG_NONE;
    buy_d  = buy_q;
    sell_d = sell_q;
    if (is_buy) begin
      sig_d = mavx_pkg::SIG_BUY;
      if (buy_q != '1) begin
        buy_d = buy_q + mavx_pkg::TOTAL_W'(1);
      end
    end else if (is_sell) begin
      sig_d = mavx_pkg::SIG_SELL;
      if (sell_q != '1) begin
        sell_d = sell_q + mavx_pkg::TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bull_q <= 1'b0;
      buy_q       <= '0;
      sell_q      <= '0;
    end else if (out_load) begin
      prev_bull_q <= s2_bull_q;
      buy_q       <= buy_d;
      sell_q      <= sell_d;
    end
  end

  // Result register for the per-item flags and signal.
  logic signed [1:0] sig_q;
  logic              short_rdy_q, long_rdy_q;

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      sig_q       <= sig_d;
      short_rdy_q <= s2_short_rdy_q;
      long_rdy_q  <= s2_long_rdy_q;
    end
  end

  assign trade_signal_o = sig_q;
  assign short_ready_o  = short_rdy_q;
  assign long_ready_o   = long_rdy_q;
  assign buy_total_o    = buy_q;
  assign sell_total_o   = sell_q;

endmodule

>>> design/mavx_checker.sv
// Port-level checks for the moving-average crossover block, bound to the top level.
module mavx_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [mavx_pkg::PRICE_W-1:0]        short_average_o,
  input logic [mavx_pkg::PRICE_W-1:0]        long_average_o,
  input logic                                short_ready_o,
  input logic                                long_ready_o,
  input logic signed [1:0]                   trade_signal_o,
  input logic [mavx_pkg::TOTAL_W-1:0]        buy_total_o,
  input logic [mavx_pkg::TOTAL_W-1:0]        sell_total_o
);

  // A crossover is only reported once the long window has filled.
  a_signal_needs_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trade_signal_o != mavx_pkg::SIG_NONE) |-> long_ready_o)
    else $error("trade signal before long window filled");

  // An unfilled window reads as a zero mean.
  a_short_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !short_ready_o |-> short_average_o == '0)
    else $error("short mean nonzero before window filled");

  a_long_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !long_ready_o |-> long_average_o == '0)
    else $error("long mean nonzero before window filled");

  // A sell request always comes with a nonzero sell total.
  a_sell_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trade_signal_o == mavx_pkg::SIG_SELL) |-> sell_total_o != '0)
    else $error("sell signal without sell total");

  // A stalled result request stays and keeps its totals.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(buy_total_o) && $stable(sell_total_o))
    else $error("stalled result request changed");

endmodule

bind moving_average_crossover mavx_checker u_mavx_checker (.*);
